### sv/ued_pkg.sv
// ----------------------------------------------------------------------------
// Echo distance package
// Shared widths, constants and the sequencer state type for the ultrasonic
// echo distance block and its checker.
// ----------------------------------------------------------------------------
package ued_pkg;

  localparam int CounterBits = 32;
  localparam int EdgeW       = 32;
  localparam int RateW       = 28;
  localparam int DigitW      = 4;
  localparam int FactorW     = 18;
  localparam int ProdW       = EdgeW + FactorW;
  localparam int TenthsW     = 14;
  localparam int BcdW        = 4 * DigitW;
  localparam int StepW       = 6;

  localparam logic [RateW-1:0]   RateReset   = RateW'(80000000);
  localparam logic [FactorW-1:0] SoundFactor = FactorW'(171600);
  localparam logic [ProdW-1:0]   MaxTenths   = ProdW'(9999);
  localparam logic [DigitW-1:0]  DigitNine   = DigitW'(9);
  localparam logic [StepW-1:0]   DivLast     = StepW'(ProdW - 1);
  localparam logic [StepW-1:0]   BcdLast     = StepW'(TenthsW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BCD,
    ST_DONE
  } ued_state_t;

endpackage

### sv/ultrasonic_echo_distance_bcd_top.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo distance to BCD
// Pairs echo edges, divides the scaled elapsed count by the counter rate with
// a shared subtractor and splits the distance into four decimal digits.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one echo edge per item: the value of the free
//   running down-counter captured at that edge. The first edge of a pair is
//   stored and gives no result. The closing edge starts the computation and
//   the block holds in_stall high until it is done. The computation captures
//   the elapsed count, multiplies it by the sound factor, runs the restoring
//   division (one quotient bit per cycle through the single subtractor),
//   converts the binary distance to BCD and loads the output register; the
//   BCD conversion is skipped when the distance saturates.
//   The result sits in an output register; while the receiver stalls it, the
//   block still accepts the next start edge, and a finished computation waits
//   in the done state until the output register is free.
//   Reset clears the pairing state, drops out_valid and sets the counter rate
//   to 80000000 ticks per second. cfg_wr_en writes the rate.
// ----------------------------------------------------------------------------
module ultrasonic_echo_distance_bcd_top
  import ued_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [RateW-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [EdgeW-1:0]  in_edge_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DigitW-1:0] out_hundreds_digit,
  output logic [DigitW-1:0] out_tens_digit,
  output logic [DigitW-1:0] out_units_digit,
  output logic [DigitW-1:0] out_tenths_digit,
  output logic              out_out_of_range
);

  ued_state_t             state_r, state_nxt;
  logic [RateW-1:0]       rate_r, rate_nxt;
  logic                   awaiting_r, awaiting_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [StepW-1:0]       step_r, step_nxt;

  logic [CounterBits-1:0] start_r, start_nxt;
  logic [CounterBits-1:0] elapsed_r, elapsed_nxt;
  logic [ProdW-1:0]       quo_r, quo_nxt;
  logic [RateW-1:0]       rem_r, rem_nxt;
  logic [BcdW-1:0]        bcd_r, bcd_nxt;
  logic                   over_r, over_nxt;
  logic [DigitW-1:0]      hun_r, hun_nxt;
  logic [DigitW-1:0]      ten_r, ten_nxt;
  logic [DigitW-1:0]      uni_r, uni_nxt;
  logic [DigitW-1:0]      tth_r, tth_nxt;
  logic                   oor_r, oor_nxt;

  logic                   in_accept;
  logic                   out_free;
  logic [RateW:0]         div_trial;
  logic [RateW+1:0]       div_diff;
  logic                   div_ge;
  logic [ProdW-1:0]       div_quo;
  logic [BcdW-1:0]        bcd_adj;
  logic                   final_over;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // One restoring division step: shift in the next dividend bit and try to
  // subtract the rate.
  assign div_trial = {rem_r, quo_r[ProdW-1]};
  assign div_diff  = {1'b0, div_trial} - {2'b00, rate_r};
  assign div_ge    = !div_diff[RateW+1];
  assign div_quo   = {quo_r[ProdW-2:0], div_ge};

  // A zero rate makes the quotient all ones, but it is flagged explicitly.
  assign final_over = (rate_r == '0) || (div_quo > MaxTenths);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (bcd_r[i*DigitW +: DigitW] >= DigitW'(5)) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_r[i*DigitW +: DigitW] + DigitW'(3);
      end else begin
        bcd_adj[i*DigitW +: DigitW] = bcd_r[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rate_nxt      = rate_r;
    awaiting_nxt  = awaiting_r;
    out_valid_nxt = out_valid_r;
    step_nxt      = step_r;
    start_nxt     = start_r;
    elapsed_nxt   = elapsed_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bcd_nxt       = bcd_r;
    over_nxt      = over_r;
    hun_nxt       = hun_r;
    ten_nxt       = ten_r;
    uni_nxt       = uni_r;
    tth_nxt       = tth_r;
    oor_nxt       = oor_r;

    if (cfg_wr_en) begin
      rate_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (!awaiting_r) begin
            start_nxt    = in_edge_count[CounterBits-1:0];
            awaiting_nxt = 1'b1;
          end else begin
            elapsed_nxt  = start_r - in_edge_count[CounterBits-1:0];
            awaiting_nxt = 1'b0;
            state_nxt    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        quo_nxt   = ProdW'(elapsed_r) * ProdW'(SoundFactor);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quo_nxt = div_quo;
        rem_nxt = div_ge ? div_diff[RateW-1:0] : div_trial[RateW-1:0];
        if (step_r == DivLast) begin
          over_nxt = final_over;
          bcd_nxt  = '0;
          step_nxt = '0;
          state_nxt = final_over ? ST_DONE : ST_BCD;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      ST_BCD: begin
        bcd_nxt = {bcd_adj[BcdW-2:0], quo_r[TenthsW-1]};
        quo_nxt = {quo_r[ProdW-2:0], 1'b0};
        if (step_r == BcdLast) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (over_r) begin
            hun_nxt = DigitNine;
            ten_nxt = DigitNine;
            uni_nxt = DigitNine;
            tth_nxt = DigitNine;
          end else begin
            hun_nxt = bcd_r[3*DigitW +: DigitW];
            ten_nxt = bcd_r[2*DigitW +: DigitW];
            uni_nxt = bcd_r[DigitW +: DigitW];
            tth_nxt = bcd_r[0 +: DigitW];
          end
          oor_nxt       = over_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= RateReset;
      awaiting_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      start_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      awaiting_r  <= awaiting_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      start_r     <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    bcd_r     <= bcd_nxt;
    over_r    <= over_nxt;
    hun_r     <= hun_nxt;
    ten_r     <= ten_nxt;
    uni_r     <= uni_nxt;
    tth_r     <= tth_nxt;
    oor_r     <= oor_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hundreds_digit = hun_r;
  assign out_tens_digit     = ten_r;
  assign out_units_digit    = uni_r;
  assign out_tenths_digit   = tth_r;
  assign out_out_of_range   = oor_r;

endmodule

### sv/ued_checker.sv
// ----------------------------------------------------------------------------
// Echo distance port checker
// Watches the top level's ports for result consistency and output handshake.
// ----------------------------------------------------------------------------
module ued_checker
  import ued_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DigitW-1:0] out_hundreds_digit,
  input logic [DigitW-1:0] out_tens_digit,
  input logic [DigitW-1:0] out_units_digit,
  input logic [DigitW-1:0] out_tenths_digit,
  input logic              out_out_of_range
);

  // A saturated item must show nines in every digit.
  a_sat_nines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_hundreds_digit == DigitNine && out_tens_digit == DigitNine &&
      out_units_digit == DigitNine && out_tenths_digit == DigitNine)
    else $error("saturated item without all nines");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hundreds_digit <= DigitNine && out_tens_digit <= DigitNine &&
      out_units_digit <= DigitNine && out_tenths_digit <= DigitNine)
    else $error("digit above nine");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hundreds_digit) &&
      $stable(out_tens_digit) && $stable(out_units_digit) &&
      $stable(out_tenths_digit) && $stable(out_out_of_range))
    else $error("stalled item changed");

endmodule

bind ultrasonic_echo_distance_bcd_top ued_checker u_ued_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_hundreds_digit (out_hundreds_digit),
  .out_tens_digit     (out_tens_digit),
  .out_units_digit    (out_units_digit),
  .out_tenths_digit   (out_tenths_digit),
  .out_out_of_range   (out_out_of_range)
);

### tb/sv/tb_ultrasonic_echo_distance_bcd_top.sv
// ----------------------------------------------------------------------------
// Echo distance to BCD testbench
// Sends echo edge items in pairs and checks every distance result against a
// predictor that pairs the edges, scales the elapsed count by the speed of
// sound and splits the distance into digits, or against the reading that a
// typed row of the short directed table gives. The table covers these cases:
//   - the reset rate
//   - equal edges
//   - a counter that wrapped between the edges
//   - the full-scale boundary
//   - a zero rate and rates at and outside the stated range
// Random phases follow, each at its own rate. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_distance_bcd_top;
  import ued_pkg::*;

  localparam logic [63:0] SpeedFactor = 64'd171600;
  localparam logic [63:0] FullScale   = 64'd9999;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 80;
  localparam int DrainCycles   = 100;
  localparam int RandomEdges   = 1700;

  typedef struct packed {
    logic [DigitW-1:0] hundreds;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] units;
    logic [DigitW-1:0] tenths;
    logic              over;
  } reading_t;

  typedef enum logic {
    ROW_EDGE,
    ROW_RATE
  } row_kind_t;

  // A row either sends one edge item or writes the counter rate. Where typed
  // is set, want is the reading that the pair closed by this edge must give.
  typedef struct packed {
    row_kind_t        kind;
    logic [EdgeW-1:0] value;
    logic             typed;
    reading_t         want;
  } stim_row_t;

  localparam reading_t ZeroReading = '{4'd0, 4'd0, 4'd0, 4'd0, 1'b0};
  localparam reading_t FullReading = '{4'd9, 4'd9, 4'd9, 4'd9, 1'b0};
  localparam reading_t Saturated   = '{4'd9, 4'd9, 4'd9, 4'd9, 1'b1};

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [RateW-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [EdgeW-1:0]  in_edge_count;
  logic              out_valid;
  logic              out_stall;
  logic [DigitW-1:0] out_hundreds_digit;
  logic [DigitW-1:0] out_tens_digit;
  logic [DigitW-1:0] out_units_digit;
  logic [DigitW-1:0] out_tenths_digit;
  logic              out_out_of_range;

  ultrasonic_echo_distance_bcd_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_edge_count     (in_edge_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hundreds_digit(out_hundreds_digit),
    .out_tens_digit    (out_tens_digit),
    .out_units_digit   (out_units_digit),
    .out_tenths_digit  (out_tenths_digit),
    .out_out_of_range  (out_out_of_range)
  );

  // Predictor state and bookkeeping.
  logic             have_start;
  logic [EdgeW-1:0] pending_start;
  logic [RateW-1:0] rate_now;
  reading_t         readings_due[$];
  stim_row_t        directed_rows[$];
  bit               calm;
  int               errors;
  int               edges_sent;
  int               readings_checked;
  int               saturated_seen;
  int               rate_writes;
  int               idle_cycles;
  reading_t         got_reading;
  reading_t         due_reading;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reading_t range_from_pair(logic [EdgeW-1:0] start_edge,
                                               logic [EdgeW-1:0] stop_edge,
                                               logic [RateW-1:0] rate);
    logic [63:0] span_mask;
    logic [63:0] elapsed;
    logic [63:0] tenths;
    reading_t    r;
    span_mask = (64'd1 << CounterBits) - 64'd1;
    elapsed   = (64'(start_edge) - 64'(stop_edge)) & span_mask;
    if (rate == '0) begin
      return Saturated;
    end
    tenths = elapsed * SpeedFactor / 64'(rate);
    if (tenths > FullScale) begin
      return Saturated;
    end
    r.hundreds = DigitW'(tenths / 1000 % 10);
    r.tens     = DigitW'(tenths / 100 % 10);
    r.units    = DigitW'(tenths / 10 % 10);
    r.tenths   = DigitW'(tenths % 10);
    r.over     = 1'b0;
    return r;
  endfunction

  // Most gaps are short; a few are long. In a calm stretch there are none.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  task automatic note_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Advances the pairing state on an accepted edge item and queues the
  // reading that the closing edge of a pair must give.
  task automatic take_edge(logic [EdgeW-1:0] edge_value, logic typed, reading_t want);
    if (!have_start) begin
      pending_start = edge_value;
      have_start    = 1'b1;
    end else begin
      have_start = 1'b0;
      readings_due.push_back(typed ? want
                                   : range_from_pair(pending_start, edge_value, rate_now));
    end
    edges_sent++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_edge(logic [EdgeW-1:0] edge_value, logic typed, reading_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_edge_count <= edge_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_edge(edge_value, typed, want);
    @(negedge clk);
  endtask

  // The rate is only written once every reading has come out and the block
  // has had time to finish any work still under way.
  task automatic set_rate(logic [RateW-1:0] rate);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rate_now  = rate;
    rate_writes++;
  endtask

  // Receiver: stretches of stall of random length between short free runs.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_reading = {out_hundreds_digit, out_tens_digit, out_units_digit,
                     out_tenths_digit, out_out_of_range};
      if (readings_due.size() == 0) begin
        note_mismatch($sformatf("distance %0d%0d%0d.%0d oor=%0d with none expected",
                                got_reading.hundreds, got_reading.tens,
                                got_reading.units, got_reading.tenths, got_reading.over));
      end else begin
        due_reading = readings_due.pop_front();
        readings_checked++;
        if (due_reading.over) begin
          saturated_seen++;
        end
        if (got_reading != due_reading) begin
          note_mismatch($sformatf("distance %0d%0d%0d.%0d oor=%0d, expected %0d%0d%0d.%0d oor=%0d",
                                  got_reading.hundreds, got_reading.tens,
                                  got_reading.units, got_reading.tenths, got_reading.over,
                                  due_reading.hundreds, due_reading.tens,
                                  due_reading.units, due_reading.tenths, due_reading.over));
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel nor the register moves.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
      $display("ultrasonic_echo_distance_bcd_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0]      reach;
    logic [EdgeW-1:0] start_edge;
    logic [EdgeW-1:0] span;
    logic [RateW-1:0] rate;
    int unsigned      pick;
    int               pairs;
    int               random_start;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_edge_count    = '0;
    have_start       = 1'b0;
    pending_start    = '0;
    rate_now         = RateW'(80000000);
    calm             = 1'b0;
    errors           = 0;
    edges_sent       = 0;
    readings_checked = 0;
    saturated_seen   = 0;
    rate_writes      = 0;
    idle_cycles      = 0;

    // Reset rate first, then a zero rate, the widest rate and rates at and
    // outside both ends of the stated range.
    directed_rows.push_back('{ROW_EDGE, 32'd100, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'd100, 1'b1, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0000_0000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'hFFFF_FFFF, 1'b1, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'hFFFF_FFFF, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0000_0000, 1'b1, Saturated});
    directed_rows.push_back('{ROW_EDGE, 32'h0100_0000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0100_0000 - 32'd4662004, 1'b1, FullReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0100_0000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0100_0000 - 32'd4662005, 1'b1, Saturated});
    directed_rows.push_back('{ROW_EDGE, 32'h8765_4321, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h8760_0000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_RATE, 32'd0, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'd5, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'd5, 1'b1, Saturated});
    directed_rows.push_back('{ROW_RATE, 32'h0FFF_FFFF, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'hFFFF_FFFF, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0000_0000, 1'b1, Saturated});
    directed_rows.push_back('{ROW_EDGE, 32'h2AAA_AAAA, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h2AAA_AAAA - 32'd1000000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_RATE, 32'd1, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h5555_5555, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h5555_5555, 1'b1, ZeroReading});
    directed_rows.push_back('{ROW_RATE, 32'd200000000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'hC000_0000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'hC000_0000 - 32'd11655011, 1'b1, FullReading});
    directed_rows.push_back('{ROW_RATE, 32'd1000000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0000_1000, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h0000_1000 - 32'd7192, 1'b1,
                              '{4'd1, 4'd2, 4'd3, 4'd4, 1'b0}});
    directed_rows.push_back('{ROW_EDGE, 32'h1234_5678, 1'b0, ZeroReading});
    directed_rows.push_back('{ROW_EDGE, 32'h1234_5678 - 32'd58276, 1'b1, Saturated});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_RATE) begin
        set_rate(directed_rows[i].value[RateW-1:0]);
      end else begin
        send_edge(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: each picks a rate, then sends whole pairs. Most elapsed
    // counts land inside full scale so that every digit value shows up.
    random_start = edges_sent;
    while (edges_sent - random_start < RandomEdges) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       rate = RateW'(80000000);
        1:       rate = RateW'(1000000);
        2:       rate = RateW'(200000000);
        3:       rate = '1;
        4:       rate = ($urandom_range(0, 5) == 0) ? '0 : RateW'($urandom_range(1, 5000));
        5:       rate = RateW'($urandom);
        default: rate = RateW'($urandom_range(1000000, 200000000));
      endcase
      set_rate(rate);
      calm  = ($urandom_range(0, 3) == 0);
      reach = (rate == '0) ? 64'd1000 : (64'd10000 * 64'(rate) - 64'd1) / SpeedFactor;
      pairs = $urandom_range(20, 60);
      repeat (pairs) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          span = $urandom_range(0, reach[31:0]);
        end else if (pick == 7) begin
          span = reach[31:0] + $urandom_range(0, 1);
        end else if (pick == 8) begin
          span = $urandom_range(0, 20);
        end else begin
          span = $urandom;
        end
        start_edge = $urandom;
        send_edge(start_edge, 1'b0, ZeroReading);
        send_edge(start_edge - span, 1'b0, ZeroReading);
      end
    end

    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d echo edges under %0d counter rate settings.", edges_sent, rate_writes);
    $display("Checked %0d distances, %0d of them saturated; %0d mismatches.",
             readings_checked, saturated_seen, errors);
    if (errors == 0) begin
      $display("ultrasonic_echo_distance_bcd_top test passed");
    end else begin
      $display("ultrasonic_echo_distance_bcd_top test failed");
    end
    $finish;
  end

endmodule
